>>> rtl/core/nclc_pkg.sv
// ---------------------------------------------------------------------------
// nclc_pkg
// Shared constants and types for the nearest center search block: default
// sizes, register indexes, and the command and status groups that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package nclc_pkg;

    // Default sizes for the top level parameters.
    localparam int DEF_MAX_CENTERS = 64;
    localparam int DEF_COORD_BITS  = 10;

    // Fixed field widths of the ports.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SLOT_W      = 6;
    localparam int POS_W       = 10;
    localparam int COUNT_W     = 7;
    localparam int MONEY_W     = 16;
    localparam int ID_W        = 7;
    localparam int DIST_OUT_W  = 11;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRICE        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_COST    = 2'd2;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // write the incoming center into the table
        logic query_start;  // capture the query point and the search limit
        logic scan_rd;      // read the next table entry
        logic cost_mul;     // form unit_cost times the best distance
        logic finish;       // register the result and raise the strobe
    } nclc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_rd;      // the read address points at the last entry
    } nclc_status_t;

endpackage

>>> rtl/core/nearest_center_l1_with_cost_check.sv
// ---------------------------------------------------------------------------
// nearest_center_l1_with_cost_check
// Nearest center search by Manhattan distance over a loaded table, with a
// check of distance cost against a price.
// ---------------------------------------------------------------------------
// A load item (func 0) writes one center into the table at the edge that
// accepts it and gives no result; busy stays low, so loads may follow each
// other in every cycle. A query item (func 1) raises busy and searches N
// centers (N is center_count, clamped to 1..MAX_CENTERS) through the single
// table read port and distance unit, which visit one center per cycle; it
// then compares the last center, forms the cost product and registers the
// result, which is shown with done high. The result transfer happens in the
// single cycle in which done is high; there is no way to hold it off, so the
// receiver must take it then. A new item may be started in that same cycle.
// Table entries hold nothing until loaded: every entry a query searches must
// have been loaded first. Configuration must be written only while busy is
// low and no result is pending; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module nearest_center_l1_with_cost_check
    import nclc_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int COORD_BITS  = DEF_COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   func,
    input  logic [SLOT_W-1:0]      slot,
    input  logic [POS_W-1:0]       pos_x,
    input  logic [POS_W-1:0]       pos_y,
    output logic                   done,
    output logic [ID_W-1:0]        center_id,
    output logic [DIST_OUT_W-1:0]  best_distance
);

    nclc_cmd_t    cmd;
    nclc_status_t status;

    // Sequencing of items and scan steps.
    nclc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Table, distance unit, cost check and result registers.
    nclc_datapath #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .slot          (slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .done          (done),
        .center_id     (center_id),
        .best_distance (best_distance)
    );

endmodule

>>> rtl/core/nclc_ctrl.sv
// ---------------------------------------------------------------------------
// nclc_ctrl
// Controller for the nearest center search. Accepts load and query items,
// steps a query through the table scan, the cost multiply and the result
// transfer.
// ---------------------------------------------------------------------------
module nclc_ctrl
    import nclc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         func,
    input  nclc_status_t status,
    output logic         busy,
    output nclc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   accept;

    // An item is taken only while no query is in progress.
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    // Commands decoded from the current state.
    always_comb
    begin
        cmd             = '0;
        cmd.load        = accept && (func == FUNC_LOAD);
        cmd.query_start = accept && (func == FUNC_QUERY);
        cmd.scan_rd     = (state_reg == ST_SCAN);
        cmd.cost_mul    = (state_reg == ST_MUL);
        cmd.finish      = (state_reg == ST_FINISH);
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (func == FUNC_QUERY))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (status.last_rd)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/nclc_datapath.sv
// ---------------------------------------------------------------------------
// nclc_datapath
// Datapath for the nearest center search: configuration registers, the
// center table, one distance and compare unit that walks the table, the
// cost multiplier and the result registers.
// ---------------------------------------------------------------------------
module nclc_datapath
    import nclc_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int COORD_BITS  = DEF_COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  nclc_cmd_t              cmd,
    output nclc_status_t           status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SLOT_W-1:0]      slot,
    input  logic [POS_W-1:0]       pos_x,
    input  logic [POS_W-1:0]       pos_y,
    output logic                   done,
    output logic [ID_W-1:0]        center_id,
    output logic [DIST_OUT_W-1:0]  best_distance
);

    localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = MONEY_W + DW;
    localparam int ENT_W = 2 * COORD_BITS;

    // Configuration registers.
    logic [COUNT_W-1:0] count_reg;
    logic [MONEY_W-1:0] price_reg;
    logic [MONEY_W-1:0] unit_cost_reg;

    // Center table, x in the upper half and y in the lower half.
    logic [ENT_W-1:0] table_mem [MAX_CENTERS];
    logic [ENT_W-1:0] rd_data_reg;

    // Scan control.
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [IDX_W-1:0]      last_idx_reg;
    logic                  rd_valid_reg;
    logic                  first_reg;
    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;

    // Running best.
    logic [DW-1:0]         best_d_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [COORD_BITS-1:0] best_x_reg;
    logic [COORD_BITS-1:0] best_y_reg;

    // Cost and result.
    logic [PW-1:0]         prod_reg;
    logic                  done_reg;
    logic [ID_W-1:0]       center_id_reg;
    logic [DIST_OUT_W-1:0] best_distance_reg;

    logic [31:0]           lim_ext;
    logic [31:0]           last_ext;
    logic                  slot_ok;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DW-1:0]         cand_dist;
    logic                  take;
    logic [IDX_W:0]        id_sum;

    // Search limit: a count of zero acts as one, a count above the table
    // size acts as the table size.
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            lim_ext = 32'd1;
        end
        else if (32'(count_reg) > 32'(MAX_CENTERS))
        begin
            lim_ext = 32'(MAX_CENTERS);
        end
        else
        begin
            lim_ext = 32'(count_reg);
        end
        last_ext = lim_ext - 32'd1;
    end

    assign slot_ok = (32'(slot) < 32'(MAX_CENTERS));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_W'(1);
            price_reg     <= '0;
            unit_cost_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CENTER_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_index == REG_PRICE)
            begin
                price_reg <= cfg_data[MONEY_W-1:0];
            end
            if (cfg_index == REG_UNIT_COST)
            begin
                unit_cost_reg <= cfg_data[MONEY_W-1:0];
            end
        end
    end

    // Table write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            table_mem[IDX_W'(slot)] <= {COORD_BITS'(pos_x), COORD_BITS'(pos_y)};
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= table_mem[rd_addr_reg];
        end
    end

    assign status.last_rd = (rd_addr_reg == last_idx_reg);

    // Distance of the entry just read and the tie order against the best.
    assign cx        = rd_data_reg[ENT_W-1:COORD_BITS];
    assign cy        = rd_data_reg[COORD_BITS-1:0];
    assign dx        = (qx_reg > cx) ? (qx_reg - cx) : (cx - qx_reg);
    assign dy        = (qy_reg > cy) ? (qy_reg - cy) : (cy - qy_reg);
    assign cand_dist = DW'(dx) + DW'(dy);

    always_comb
    begin
        priority if (first_reg || (cand_dist < best_d_reg))
        begin
            take = 1'b1;
        end
        else if (cand_dist == best_d_reg)
        begin
            take = (cx < best_x_reg) || ((cx == best_x_reg) && (cy < best_y_reg));
        end
        else
        begin
            take = 1'b0;
        end
    end

    // Scan address and read valid tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.query_start)
            begin
                rd_addr_reg <= '0;
                first_reg   <= 1'b1;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                end
                if (rd_valid_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // Query capture and running best update.
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qx_reg       <= COORD_BITS'(pos_x);
            qy_reg       <= COORD_BITS'(pos_y);
            last_idx_reg <= IDX_W'(last_ext);
        end
        if (cmd.scan_rd)
        begin
            cmp_idx_reg <= rd_addr_reg;
        end
        if (rd_valid_reg && take)
        begin
            best_d_reg   <= cand_dist;
            best_idx_reg <= cmp_idx_reg;
            best_x_reg   <= cx;
            best_y_reg   <= cy;
        end
        if (cmd.cost_mul)
        begin
            prod_reg <= PW'(unit_cost_reg) * PW'(best_d_reg);
        end
    end

    // Result registers; the strobe stands for one cycle.
    assign id_sum = {1'b0, best_idx_reg} + (IDX_W + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            center_id_reg     <= (prod_reg > PW'(price_reg)) ? '0 : ID_W'(id_sum);
            best_distance_reg <= DIST_OUT_W'(best_d_reg);
        end
    end

    assign done          = done_reg;
    assign center_id     = center_id_reg;
    assign best_distance = best_distance_reg;

endmodule

>>> tb/nearest_center_l1_with_cost_check_test.sv
// ---------------------------------------------------------------------------
// nearest_center_l1_with_cost_check_test
// Self-checking testbench for the nearest center search block. Load and
// query commands are driven through the start/busy port with random gaps.
// A scoreboard keeps its own copy of the center table and the registers,
// predicts each query answer, and compares every result transfer against the
// oldest prediction. The run steps through several register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import nclc_pkg::*;

// One predicted or observed query answer.
typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [DIST_OUT_W-1:0] distance;
} placement_t;

// Scoreboard: holds the mirrored table and registers, and the queue of
// answers that are still on their way.
class center_search_book;
    logic [POS_W-1:0]     site_x [DEF_MAX_CENTERS];
    logic [POS_W-1:0]     site_y [DEF_MAX_CENTERS];
    logic [COUNT_W-1:0]   count_reg;
    logic [MONEY_W-1:0]   price_reg;
    logic [MONEY_W-1:0]   rate_reg;
    placement_t           awaited [$];
    int                   errors;

    function new();
        count_reg = 7'd1;
        price_reg = '0;
        rate_reg  = '0;
        errors    = 0;
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    function int pending();
        return awaited.size();
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER_COUNT: count_reg = data[COUNT_W-1:0];
            REG_PRICE:        price_reg = data[MONEY_W-1:0];
            REG_UNIT_COST:    rate_reg  = data[MONEY_W-1:0];
            default:          ;
        endcase
    endfunction

    // Manhattan distance between two points.
    function logic [DIST_OUT_W-1:0] span(logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
                                         logic [POS_W-1:0] bx, logic [POS_W-1:0] by);
        logic [DIST_OUT_W-1:0] dx;
        logic [DIST_OUT_W-1:0] dy;
        dx = (ax > bx) ? DIST_OUT_W'(ax - bx) : DIST_OUT_W'(bx - ax);
        dy = (ay > by) ? DIST_OUT_W'(ay - by) : DIST_OUT_W'(by - ay);
        return dx + dy;
    endfunction

    // Scan the searched entries; ties go to smaller x, then smaller y, then
    // the earlier entry. The center number drops to zero when the distance
    // cost is above the price.
    function placement_t nearest_center(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        int                    n;
        int                    best_i;
        logic [DIST_OUT_W-1:0] best_d;
        logic [DIST_OUT_W-1:0] d;
        logic [POS_W-1:0]      bx;
        logic [POS_W-1:0]      by;
        longint unsigned       cost;
        placement_t            r;
        n = count_reg;
        if (n == 0)
            n = 1;
        if (n > DEF_MAX_CENTERS)
            n = DEF_MAX_CENTERS;
        best_i = 0;
        bx = site_x[0];
        by = site_y[0];
        best_d = span(px, py, bx, by);
        for (int i = 1; i < n; i++)
        begin
            d = span(px, py, site_x[i], site_y[i]);
            if (d < best_d || (d == best_d && (site_x[i] < bx ||
                (site_x[i] == bx && site_y[i] < by))))
            begin
                best_i = i;
                best_d = d;
                bx = site_x[i];
                by = site_y[i];
            end
        end
        cost = rate_reg;
        cost = cost * best_d;
        r.id = (cost > price_reg) ? '0 : ID_W'(best_i + 1);
        r.distance = best_d;
        return r;
    endfunction

    // An accepted load updates the table; an accepted query queues an answer.
    function void note_item(logic f, logic [SLOT_W-1:0] s,
                            logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        if (f == FUNC_LOAD)
        begin
            site_x[s] = x;
            site_y[s] = y;
        end
        else
            awaited.push_back(nearest_center(x, y));
    endfunction

    task check_result(logic [ID_W-1:0] id, logic [DIST_OUT_W-1:0] distance);
        placement_t want;
        if (awaited.size() == 0)
            report_mismatch($sformatf("result id=%0d distance=%0d with no query waiting",
                                      id, distance));
        else
        begin
            want = awaited.pop_front();
            if (id !== want.id)
                report_mismatch($sformatf("center_id %0d, predicted %0d", id, want.id));
            if (distance !== want.distance)
                report_mismatch($sformatf("best_distance %0d, predicted %0d",
                                          distance, want.distance));
        end
    endtask
endclass

module nearest_center_l1_with_cost_check_test;
    import nclc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 115;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   func = FUNC_LOAD;
    logic [SLOT_W-1:0]      slot = '0;
    logic [POS_W-1:0]       pos_x = '0;
    logic [POS_W-1:0]       pos_y = '0;
    logic                   done;
    logic [ID_W-1:0]        center_id;
    logic [DIST_OUT_W-1:0]  best_distance;

    center_search_book book;
    int  cycle_count = 0;
    bit  quiet_stretch = 1'b0;

    nearest_center_l1_with_cost_check uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .slot          (slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .done          (done),
        .center_id     (center_id),
        .best_distance (best_distance)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result transfers: values seen at the edge are those of the done cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            book.check_result(center_id, best_distance);
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("nearest_center_l1_with_cost_check_test: done, errors");
        $finish;
    end

    function int draw_gap();
        return quiet_stretch ? 0 : $urandom_range(0, 14);
    endfunction

    // Coordinate styles: full range, a small corner cluster for ties,
    // the two extremes, and a cluster at the top end.
    function logic [POS_W-1:0] pick_coord(int style);
        case (style)
            0:       return POS_W'($urandom_range(0, 1023));
            1:       return POS_W'($urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            default: return POS_W'($urandom_range(1016, 1023));
        endcase
    endfunction

    // Drive one command and wait for its transfer. Start stays high when the
    // next command follows with no gap.
    task automatic send_item(logic f, logic [SLOT_W-1:0] s,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func  <= f;
        slot  <= s;
        pos_x <= x;
        pos_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_item(f, s, x, y);
    endtask

    task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.set_register(idx, data);
        @(posedge clk);
    endtask

    // Drop start, let every query answer arrive, then allow a few cycles for
    // the last load to settle before touching the registers.
    task automatic wait_until_idle();
        start <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic query(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        send_item(FUNC_QUERY, SLOT_W'($urandom_range(0, 63)), x, y, draw_gap());
    endtask

    task automatic load(logic [SLOT_W-1:0] s, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        send_item(FUNC_LOAD, s, x, y, draw_gap());
    endtask

    initial
    begin
        int count_val;
        int style;
        book = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset settings: one center searched, no cost.
        load(6'd0, 10'd0, 10'd0);
        query(10'd0, 10'd0);
        query(10'd1023, 10'd1023);
        load(6'd1, 10'd1023, 10'd1023);
        load(6'd2, 10'd1023, 10'd0);
        load(6'd3, 10'd0, 10'd1023);
        load(6'd4, 10'd3, 10'd5);
        load(6'd5, 10'd5, 10'd3);
        load(6'd6, 10'd3, 10'd5);
        load(6'd7, 10'd3, 10'd1);
        wait_until_idle();
        set_register(REG_CENTER_COUNT, 16'd8);

        // Ties on distance: smaller x wins, then smaller y, then earlier entry.
        query(10'd4, 10'd4);
        query(10'd5, 10'd5);
        query(10'd3, 10'd3);
        query(10'd1023, 10'd1023);
        query(10'd600, 10'd600);
        wait_until_idle();

        // Cost equal to the price keeps the center; above it clears it.
        set_register(REG_PRICE, 16'd10);
        set_register(REG_UNIT_COST, 16'd5);
        query(10'd4, 10'd4);
        query(10'd6, 10'd6);
        wait_until_idle();
        set_register(REG_PRICE, 16'd0);
        set_register(REG_UNIT_COST, 16'hFFFF);
        query(10'd0, 10'd0);
        query(10'd1, 10'd0);
        wait_until_idle();

        // Largest price and rate; then a count of zero searches one entry.
        set_register(REG_PRICE, 16'hFFFF);
        query(10'd1023, 10'd1023);
        wait_until_idle();
        set_register(REG_CENTER_COUNT, 16'd0);
        query(10'd1023, 10'd1023);

        // Fill the whole table so every later count is safe to search.
        for (int s = 0; s < DEF_MAX_CENTERS; s++)
            load(SLOT_W'(s), pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)));

        // Random phases, each with its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_idle();
            case (p)
                0:       count_val = 64;
                1:       count_val = 1;
                2:       count_val = 0;
                3:       count_val = 127;
                4:       count_val = 2;
                6:       count_val = $urandom_range(65, 127);
                7:       count_val = 64;
                8:       count_val = $urandom_range(1, 16);
                default: count_val = $urandom_range(1, 64);
            endcase
            // The upper data bits are outside the count register.
            set_register(REG_CENTER_COUNT,
                         {(p % 2 == 0) ? 9'd0 : 9'($urandom_range(0, 511)), 7'(count_val)});
            case (p)
                0:
                begin
                    set_register(REG_PRICE, 16'hFFFF);
                    set_register(REG_UNIT_COST, 16'd0);
                end
                2:
                begin
                    set_register(REG_PRICE, 16'd0);
                    set_register(REG_UNIT_COST, 16'd0);
                end
                3:
                begin
                    set_register(REG_PRICE, 16'd0);
                    set_register(REG_UNIT_COST, 16'hFFFF);
                end
                4:
                begin
                    set_register(REG_PRICE, 16'hFFFF);
                    set_register(REG_UNIT_COST, 16'hFFFF);
                end
                8:
                begin
                    set_register(REG_PRICE, 16'($urandom_range(0, 65535)));
                    set_register(REG_UNIT_COST, 16'd1);
                end
                6:
                begin
                    set_register(REG_PRICE, 16'($urandom_range(0, 65535)));
                    set_register(REG_UNIT_COST, 16'($urandom_range(0, 65535)));
                end
                default:
                begin
                    set_register(REG_PRICE, 16'($urandom_range(0, 65535)));
                    set_register(REG_UNIT_COST, 16'($urandom_range(0, 255)));
                end
            endcase
            // The spare index holds no register and must change nothing.
            if (p == 5)
                set_register(REG_SPARE, 16'($urandom_range(0, 65535)));
            quiet_stretch = (p % 3 == 2);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: style = 0;
                    5, 6, 7:       style = 1;
                    8:             style = 2;
                    default:       style = 3;
                endcase
                if ($urandom_range(0, 3) == 0)
                    load(SLOT_W'($urandom_range(0, 63)), pick_coord(style), pick_coord(style));
                else
                    query(pick_coord(style), pick_coord(style));
            end
        end

        // Drain outstanding answers, then watch for stray result transfers.
        wait_until_idle();
        repeat (80) @(posedge clk);
        if (book.pending() != 0)
            book.report_mismatch($sformatf("%0d predicted answers never arrived",
                                           book.pending()));
        if (book.errors == 0)
            $display("nearest_center_l1_with_cost_check_test: done, clean");
        else
            $display("nearest_center_l1_with_cost_check_test: done, errors");
        $finish;
    end

endmodule
